// ===== hdl/http_response_head_parser_core_assert.svh =====
// Assertion macros used by the response head parser controller.
// Expects i_clk and i_rst_n in the scope of use.
`ifndef HTTP_RESPONSE_HEAD_PARSER_CORE_ASSERT_SVH
`define HTTP_RESPONSE_HEAD_PARSER_CORE_ASSERT_SVH

// same-cycle implication
`define HRHP_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HRHP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/hrhp_pkg.sv =====
// Types, character constants and helpers for the HTTP response head parser.
// No dependencies.
package hrhp_pkg;

    localparam int WS_HOLD_DEPTH_DFLT = 15;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [2:0] LIT_LAST = 3'd4;

    typedef enum logic [3:0] {
        PH_LIT, PH_MAJOR, PH_DOT, PH_MINOR, PH_SP1, PH_CODE, PH_SP2, PH_REASON,
        PH_LINE, PH_NAME, PH_OWS, PH_VALUE, PH_VAL_LF, PH_END_LF, PH_BODY
    } t_phase;

    typedef enum logic [3:0] {
        EV_STATUS, EV_REASON, EV_NAME, EV_NAME_END, EV_VALUE,
        EV_HDR_END, EV_DONE, EV_BODY, EV_ERROR
    } t_event;

    typedef enum logic [2:0] {
        ERR_NONE, ERR_UNEXPECTED, ERR_NAME_CHAR, ERR_TRUNCATED, ERR_WS_OVERFLOW
    } t_err;

    // what the output stage emits next
    typedef enum logic [1:0] {
        ST_IDLE, ST_REPLAY, ST_PRIM, ST_TRUNC
    } t_ctl_state;

    typedef struct packed {
        logic       accept;
        logic       emit;
        logic       last;
        t_ctl_state sel;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic rep_nz;
        logic rep_more;
        logic job_prim;
        logic job_trunc;
        logic new_rep_nz;
        logic new_prim;
        logic new_trunc;
    } t_sts;

    // "HTTP/" literal
    function automatic logic [7:0] lit_char(input logic [2:0] idx);
        logic [7:0] ch;
        unique case (idx)
            3'd0:    ch = 8'h48;
            3'd1:    ch = 8'h54;
            3'd2:    ch = 8'h54;
            3'd3:    ch = 8'h50;
            3'd4:    ch = 8'h2F;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

// ===== hdl/hrhp_in_if.sv =====
// Input byte channel of the response head parser.
// Depends on nothing.
interface hrhp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       start_of_message;
    logic       end_of_message;

    modport source (output valid, data_byte, start_of_message, end_of_message,
                    input ready);
    modport sink   (input valid, data_byte, start_of_message, end_of_message,
                    output ready);
endinterface

// ===== hdl/hrhp_out_if.sv =====
// Event channel of the response head parser.
// Depends on nothing.
interface hrhp_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] event_kind;
    logic [7:0] out_byte;
    logic [3:0] ver_major;
    logic [3:0] ver_minor;
    logic [9:0] resp_code;
    logic [2:0] error_code;
    logic       last_of_run;

    modport source (output valid, event_kind, out_byte, ver_major, ver_minor,
                    resp_code, error_code, last_of_run, input ready);
    modport sink   (input valid, event_kind, out_byte, ver_major, ver_minor,
                    resp_code, error_code, last_of_run, output ready);
endinterface

// ===== hdl/hrhp_dpath.sv =====
// Parser datapath: parse state, byte decode, pending job and output register.
// Depends on hrhp_pkg and hrhp_out_if.
module hrhp_dpath #(
    parameter int WS_HOLD_DEPTH = hrhp_pkg::WS_HOLD_DEPTH_DFLT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [7:0]       i_data_byte,
    input  logic             i_som,
    input  logic             i_eom,
    input  hrhp_pkg::t_cmd   i_cmd,
    output hrhp_pkg::t_sts   o_sts,
    hrhp_out_if.source       o_out
);

    localparam int CW = $clog2(WS_HOLD_DEPTH + 1);
    localparam logic [WS_HOLD_DEPTH-1:0] KIND_ONE = WS_HOLD_DEPTH'(1);

    // parse state
    hrhp_pkg::t_phase         r_phase, n_phase;
    logic [2:0]               r_lit_idx, n_lit_idx;
    logic [3:0]               r_major, n_major;
    logic [3:0]               r_minor, n_minor;
    logic [9:0]               r_code, n_code;
    logic [1:0]               r_code_cnt, n_code_cnt;
    logic [8:0]               r_held, n_held;
    logic [CW-1:0]            r_ws_cnt, n_ws_cnt;
    logic [WS_HOLD_DEPTH-1:0] r_ws_kinds, n_ws_kinds;
    logic                     r_err, n_err;

    // decode of the incoming byte
    logic                     d_prim;
    hrhp_pkg::t_event         d_kind;
    logic [7:0]               d_byte;
    logic [3:0]               d_maj, d_min;
    logic [9:0]               d_code;
    hrhp_pkg::t_err           d_errc;
    logic [CW-1:0]            d_rep_cnt;
    logic [WS_HOLD_DEPTH-1:0] d_rep_kinds;
    logic                     d_trunc;
    logic                     do_name, do_value;
    logic                     c_digit;
    logic [3:0]               c_dig;

    // pending job
    logic [CW-1:0]            r_rep_cnt;
    logic [WS_HOLD_DEPTH-1:0] r_rep_kinds;
    logic                     r_job_prim, r_job_trunc;
    hrhp_pkg::t_event         r_prim_kind;
    logic [7:0]               r_prim_byte;
    logic [3:0]               r_prim_maj, r_prim_min;
    logic [9:0]               r_prim_code;
    hrhp_pkg::t_err           r_prim_err;

    // output register
    logic                     r_o_valid;
    hrhp_pkg::t_event         r_o_kind;
    logic [7:0]               r_o_byte;
    logic [3:0]               r_o_maj, r_o_min;
    logic [9:0]               r_o_code;
    hrhp_pkg::t_err           r_o_err;
    logic                     r_o_last;

    function automatic logic is_tchar(input logic [7:0] c);
        logic ok;
        ok = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
             (c >= 8'h61 && c <= 8'h7A);
        case (c)
            8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A, 8'h2B,
            8'h2D, 8'h2E, 8'h5E, 8'h5F, 8'h60, 8'h7C, 8'h7E: ok = 1'b1;
            default: ;
        endcase
        return ok;
    endfunction

    assign c_digit = (i_data_byte >= hrhp_pkg::CH_ZERO) && (i_data_byte <= hrhp_pkg::CH_NINE);
    assign c_dig   = 4'(i_data_byte - hrhp_pkg::CH_ZERO);

    always_comb begin
        n_phase    = r_phase;
        n_lit_idx  = r_lit_idx;
        n_major    = r_major;
        n_minor    = r_minor;
        n_code     = r_code;
        n_code_cnt = r_code_cnt;
        n_held     = r_held;
        n_ws_cnt   = r_ws_cnt;
        n_ws_kinds = r_ws_kinds;
        n_err      = r_err;
        if (i_som) begin
            n_phase    = hrhp_pkg::PH_LIT;
            n_lit_idx  = '0;
            n_major    = '0;
            n_minor    = '0;
            n_code     = '0;
            n_code_cnt = '0;
            n_held     = '0;
            n_ws_cnt   = '0;
            n_ws_kinds = '0;
            n_err      = 1'b0;
        end

        d_prim      = 1'b0;
        d_kind      = hrhp_pkg::EV_STATUS;
        d_byte      = '0;
        d_maj       = '0;
        d_min       = '0;
        d_code      = '0;
        d_errc      = hrhp_pkg::ERR_NONE;
        d_rep_cnt   = '0;
        d_rep_kinds = '0;
        do_name     = 1'b0;
        do_value    = 1'b0;

        if (!n_err) begin
            unique case (n_phase)
                hrhp_pkg::PH_LIT: begin
                    if (n_lit_idx <= hrhp_pkg::LIT_LAST &&
                        i_data_byte == hrhp_pkg::lit_char(n_lit_idx)) begin
                        if (n_lit_idx == hrhp_pkg::LIT_LAST) n_phase = hrhp_pkg::PH_MAJOR;
                        n_lit_idx = n_lit_idx + 3'd1;
                    end else begin
                        n_err = 1'b1; d_prim = 1'b1; d_kind = hrhp_pkg::EV_ERROR;
                        d_errc = hrhp_pkg::ERR_UNEXPECTED;
                    end
                end
                hrhp_pkg::PH_MAJOR, hrhp_pkg::PH_MINOR: begin
                    if (c_digit) begin
                        if (n_phase == hrhp_pkg::PH_MAJOR) begin
                            n_major = c_dig;
                            n_phase = hrhp_pkg::PH_DOT;
                        end else begin
                            n_minor = c_dig;
                            n_phase = hrhp_pkg::PH_SP1;
                        end
                    end else begin
                        n_err = 1'b1; d_prim = 1'b1; d_kind = hrhp_pkg::EV_ERROR;
                        d_errc = hrhp_pkg::ERR_UNEXPECTED;
                    end
                end
                hrhp_pkg::PH_DOT: begin
                    if (i_data_byte == hrhp_pkg::CH_DOT) n_phase = hrhp_pkg::PH_MINOR;
                    else begin
                        n_err = 1'b1; d_prim = 1'b1; d_kind = hrhp_pkg::EV_ERROR;
                        d_errc = hrhp_pkg::ERR_UNEXPECTED;
                    end
                end
                hrhp_pkg::PH_SP1: begin
                    if (i_data_byte == hrhp_pkg::CH_SP) n_phase = hrhp_pkg::PH_CODE;
                    else begin
                        n_err = 1'b1; d_prim = 1'b1; d_kind = hrhp_pkg::EV_ERROR;
                        d_errc = hrhp_pkg::ERR_UNEXPECTED;
                    end
                end
                hrhp_pkg::PH_CODE: begin
                    if (c_digit) begin
                        n_code = 10'(n_code * 10'd10 + 10'(c_dig));
                        if (n_code_cnt == 2'd2) n_phase = hrhp_pkg::PH_SP2;
                        n_code_cnt = n_code_cnt + 2'd1;
                    end else begin
                        n_err = 1'b1; d_prim = 1'b1; d_kind = hrhp_pkg::EV_ERROR;
                        d_errc = hrhp_pkg::ERR_UNEXPECTED;
                    end
                end
                hrhp_pkg::PH_SP2: begin
                    if (i_data_byte == hrhp_pkg::CH_SP) begin
                        d_prim  = 1'b1;
                        d_kind  = hrhp_pkg::EV_STATUS;
                        d_maj   = n_major;
                        d_min   = n_minor;
                        d_code  = n_code;
                        n_held  = '0;
                        n_phase = hrhp_pkg::PH_REASON;
                    end else begin
                        n_err = 1'b1; d_prim = 1'b1; d_kind = hrhp_pkg::EV_ERROR;
                        d_errc = hrhp_pkg::ERR_UNEXPECTED;
                    end
                end
                hrhp_pkg::PH_REASON: begin
                    // one byte held back so the byte before LF is dropped
                    if (i_data_byte == hrhp_pkg::CH_LF) begin
                        n_held  = '0;
                        n_phase = hrhp_pkg::PH_LINE;
                    end else begin
                        if (n_held[8]) begin
                            d_prim = 1'b1;
                            d_kind = hrhp_pkg::EV_REASON;
                            d_byte = n_held[7:0];
                        end
                        n_held = {1'b1, i_data_byte};
                    end
                end
                hrhp_pkg::PH_LINE: begin
                    if (i_data_byte == hrhp_pkg::CH_CR) n_phase = hrhp_pkg::PH_END_LF;
                    else do_name = 1'b1;
                end
                hrhp_pkg::PH_NAME:  do_name = 1'b1;
                hrhp_pkg::PH_OWS: begin
                    if (i_data_byte != hrhp_pkg::CH_SP && i_data_byte != hrhp_pkg::CH_TAB)
                        do_value = 1'b1;
                end
                hrhp_pkg::PH_VALUE: do_value = 1'b1;
                hrhp_pkg::PH_VAL_LF, hrhp_pkg::PH_END_LF: begin
                    if (i_data_byte == hrhp_pkg::CH_LF) begin
                        d_prim = 1'b1;
                        if (n_phase == hrhp_pkg::PH_VAL_LF) begin
                            d_kind  = hrhp_pkg::EV_HDR_END;
                            n_phase = hrhp_pkg::PH_LINE;
                        end else begin
                            d_kind  = hrhp_pkg::EV_DONE;
                            n_phase = hrhp_pkg::PH_BODY;
                        end
                    end else begin
                        n_err = 1'b1; d_prim = 1'b1; d_kind = hrhp_pkg::EV_ERROR;
                        d_errc = hrhp_pkg::ERR_UNEXPECTED;
                    end
                end
                hrhp_pkg::PH_BODY: begin
                    d_prim = 1'b1;
                    d_kind = hrhp_pkg::EV_BODY;
                    d_byte = i_data_byte;
                end
                default: begin
                    n_err = 1'b1; d_prim = 1'b1; d_kind = hrhp_pkg::EV_ERROR;
                    d_errc = hrhp_pkg::ERR_UNEXPECTED;
                end
            endcase

            if (do_name) begin
                if (i_data_byte == hrhp_pkg::CH_COLON) begin
                    d_prim  = 1'b1;
                    d_kind  = hrhp_pkg::EV_NAME_END;
                    n_phase = hrhp_pkg::PH_OWS;
                end else if (is_tchar(i_data_byte)) begin
                    d_prim  = 1'b1;
                    d_kind  = hrhp_pkg::EV_NAME;
                    d_byte  = i_data_byte;
                    n_phase = hrhp_pkg::PH_NAME;
                end else begin
                    n_err = 1'b1; d_prim = 1'b1; d_kind = hrhp_pkg::EV_ERROR;
                    d_errc = hrhp_pkg::ERR_NAME_CHAR;
                end
            end

            if (do_value) begin
                n_phase = hrhp_pkg::PH_VALUE;
                if (i_data_byte == hrhp_pkg::CH_CR) begin
                    // held whitespace is dropped at line end
                    n_ws_cnt   = '0;
                    n_ws_kinds = '0;
                    n_phase    = hrhp_pkg::PH_VAL_LF;
                end else if (i_data_byte == hrhp_pkg::CH_SP ||
                             i_data_byte == hrhp_pkg::CH_TAB) begin
                    if (n_ws_cnt >= CW'(WS_HOLD_DEPTH)) begin
                        n_err = 1'b1; d_prim = 1'b1; d_kind = hrhp_pkg::EV_ERROR;
                        d_errc = hrhp_pkg::ERR_WS_OVERFLOW;
                    end else begin
                        if (i_data_byte == hrhp_pkg::CH_TAB)
                            n_ws_kinds = n_ws_kinds | (KIND_ONE << n_ws_cnt);
                        n_ws_cnt = n_ws_cnt + CW'(1);
                    end
                end else if (i_data_byte < hrhp_pkg::CH_SP) begin
                    n_err = 1'b1; d_prim = 1'b1; d_kind = hrhp_pkg::EV_ERROR;
                    d_errc = hrhp_pkg::ERR_UNEXPECTED;
                end else begin
                    // visible byte: replay held whitespace first
                    d_rep_cnt   = n_ws_cnt;
                    d_rep_kinds = n_ws_kinds;
                    n_ws_cnt    = '0;
                    n_ws_kinds  = '0;
                    d_prim      = 1'b1;
                    d_kind      = hrhp_pkg::EV_VALUE;
                    d_byte      = i_data_byte;
                end
            end
        end

        d_trunc = i_eom && !n_err && (n_phase != hrhp_pkg::PH_BODY);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= hrhp_pkg::PH_LIT;
            r_lit_idx  <= '0;
            r_major    <= '0;
            r_minor    <= '0;
            r_code     <= '0;
            r_code_cnt <= '0;
            r_held     <= '0;
            r_ws_cnt   <= '0;
            r_ws_kinds <= '0;
            r_err      <= 1'b0;
        end else if (i_cmd.accept) begin
            r_phase    <= n_phase;
            r_lit_idx  <= n_lit_idx;
            r_major    <= n_major;
            r_minor    <= n_minor;
            r_code     <= n_code;
            r_code_cnt <= n_code_cnt;
            r_held     <= n_held;
            r_ws_cnt   <= n_ws_cnt;
            r_ws_kinds <= n_ws_kinds;
            r_err      <= n_err;
        end
    end

    // job control fields
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rep_cnt   <= '0;
            r_job_prim  <= 1'b0;
            r_job_trunc <= 1'b0;
        end else if (i_cmd.accept) begin
            r_rep_cnt   <= d_rep_cnt;
            r_job_prim  <= d_prim;
            r_job_trunc <= d_trunc;
        end else if (i_cmd.emit && i_cmd.sel == hrhp_pkg::ST_REPLAY) begin
            r_rep_cnt   <= r_rep_cnt - CW'(1);
        end
    end

    // job payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_rep_kinds <= d_rep_kinds;
            r_prim_kind <= d_kind;
            r_prim_byte <= d_byte;
            r_prim_maj  <= d_maj;
            r_prim_min  <= d_min;
            r_prim_code <= d_code;
            r_prim_err  <= d_errc;
        end else if (i_cmd.emit && i_cmd.sel == hrhp_pkg::ST_REPLAY) begin
            r_rep_kinds <= r_rep_kinds >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_o_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_last <= i_cmd.last;
            case (i_cmd.sel)
                hrhp_pkg::ST_REPLAY: begin
                    r_o_kind <= hrhp_pkg::EV_VALUE;
                    r_o_byte <= r_rep_kinds[0] ? hrhp_pkg::CH_TAB : hrhp_pkg::CH_SP;
                    r_o_maj  <= '0;
                    r_o_min  <= '0;
                    r_o_code <= '0;
                    r_o_err  <= hrhp_pkg::ERR_NONE;
                end
                hrhp_pkg::ST_PRIM: begin
                    r_o_kind <= r_prim_kind;
                    r_o_byte <= r_prim_byte;
                    r_o_maj  <= r_prim_maj;
                    r_o_min  <= r_prim_min;
                    r_o_code <= r_prim_code;
                    r_o_err  <= r_prim_err;
                end
                default: begin
                    r_o_kind <= hrhp_pkg::EV_ERROR;
                    r_o_byte <= '0;
                    r_o_maj  <= '0;
                    r_o_min  <= '0;
                    r_o_code <= '0;
                    r_o_err  <= hrhp_pkg::ERR_TRUNCATED;
                end
            endcase
        end
    end

    assign o_out.valid       = r_o_valid;
    assign o_out.event_kind  = r_o_kind;
    assign o_out.out_byte    = r_o_byte;
    assign o_out.ver_major   = r_o_maj;
    assign o_out.ver_minor   = r_o_min;
    assign o_out.resp_code   = r_o_code;
    assign o_out.error_code  = r_o_err;
    assign o_out.last_of_run = r_o_last;

    assign o_sts.out_free   = !r_o_valid || o_out.ready;
    assign o_sts.rep_nz     = (r_rep_cnt != '0);
    assign o_sts.rep_more   = (r_rep_cnt > CW'(1));
    assign o_sts.job_prim   = r_job_prim;
    assign o_sts.job_trunc  = r_job_trunc;
    assign o_sts.new_rep_nz = (d_rep_cnt != '0);
    assign o_sts.new_prim   = d_prim;
    assign o_sts.new_trunc  = d_trunc;

endmodule

// ===== hdl/hrhp_ctrl.sv =====
// Parser controller: sequences the words of each byte's job onto the output.
// Depends on hrhp_pkg and http_response_head_parser_core_assert.svh.
`include "http_response_head_parser_core_assert.svh"

module hrhp_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  hrhp_pkg::t_sts i_sts,
    output hrhp_pkg::t_cmd o_cmd
);

    hrhp_pkg::t_ctl_state r_state, n_state;
    hrhp_pkg::t_ctl_state after_emit, first_new;
    logic                 emit, accept, last;

    // outputs
    always_comb begin
        unique case (r_state)
            hrhp_pkg::ST_REPLAY:
                after_emit = i_sts.rep_more  ? hrhp_pkg::ST_REPLAY :
                             i_sts.job_prim  ? hrhp_pkg::ST_PRIM   :
                             i_sts.job_trunc ? hrhp_pkg::ST_TRUNC  : hrhp_pkg::ST_IDLE;
            hrhp_pkg::ST_PRIM:
                after_emit = i_sts.job_trunc ? hrhp_pkg::ST_TRUNC : hrhp_pkg::ST_IDLE;
            hrhp_pkg::ST_TRUNC: after_emit = hrhp_pkg::ST_IDLE;
            hrhp_pkg::ST_IDLE:  after_emit = hrhp_pkg::ST_IDLE;
            default:            after_emit = hrhp_pkg::ST_IDLE;
        endcase

        first_new = i_sts.new_rep_nz ? hrhp_pkg::ST_REPLAY :
                    i_sts.new_prim   ? hrhp_pkg::ST_PRIM   :
                    i_sts.new_trunc  ? hrhp_pkg::ST_TRUNC  : hrhp_pkg::ST_IDLE;

        emit       = (r_state != hrhp_pkg::ST_IDLE) && i_sts.out_free;
        last       = emit && (after_emit == hrhp_pkg::ST_IDLE);
        // the job register frees as its final word leaves
        o_in_ready = (r_state == hrhp_pkg::ST_IDLE) || last;
        accept     = i_in_valid && o_in_ready;

        o_cmd.accept = accept;
        o_cmd.emit   = emit;
        o_cmd.last   = last;
        o_cmd.sel    = r_state;
    end

    // next state
    always_comb begin
        if (accept)    n_state = first_new;
        else if (emit) n_state = after_emit;
        else           n_state = r_state;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hrhp_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `HRHP_ASSERT_IMPL(a_replay_has_count, r_state == hrhp_pkg::ST_REPLAY, i_sts.rep_nz, "replay without held whitespace")
    `HRHP_ASSERT_IMPL(a_prim_loaded, r_state == hrhp_pkg::ST_PRIM, i_sts.job_prim, "primary word not loaded")
    `HRHP_ASSERT_IMPL(a_trunc_is_last, emit && r_state == hrhp_pkg::ST_TRUNC, last, "truncation word not last of run")
    `HRHP_ASSERT_NEXT(a_more_after_nonlast, emit && !last, r_state != hrhp_pkg::ST_IDLE, "job dropped before its last word")

endmodule

// ===== hdl/http_response_head_parser_core.sv =====
// HTTP response head parser, one byte word in, event words out.
// Event words pass through the job register and then the output register.
// Takes 1 byte per cycle, but each held whitespace byte replayed ahead of a visible
// value byte, and a truncation word after the byte's own word, adds a word to its
// job and holds off the next byte; a stalled output holds off further bytes.
// Synchronous active-low reset returns the parser to the start of the status line.
module http_response_head_parser_core #(
    parameter int WS_HOLD_DEPTH = hrhp_pkg::WS_HOLD_DEPTH_DFLT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hrhp_in_if.sink     i_in,
    hrhp_out_if.source  o_out
);

    hrhp_pkg::t_cmd cmd;
    hrhp_pkg::t_sts sts;
    logic           in_ready;

    hrhp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    hrhp_dpath #(
        .WS_HOLD_DEPTH (WS_HOLD_DEPTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_data_byte (i_in.data_byte),
        .i_som       (i_in.start_of_message),
        .i_eom       (i_in.end_of_message),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out       (o_out)
    );

    assign i_in.ready = in_ready;

endmodule
